// File: rtl/eetf_pkg.sv
// eetf_pkg: shared types, constants and the cordic angle table
// used by the easing lanes, the angle unit and the top level
package eetf_pkg;

  localparam int MAX_STEPS = 15;
  localparam int COORD_W   = 32;
  localparam int ANG_W     = 16;
  localparam int DIV_W     = 16;
  localparam int SNAP_W    = 21;
  localparam int CNT_W     = 5;
  localparam int LANES     = 6;

  localparam logic [1:0] REG_SPEED  = 2'd0;
  localparam logic [1:0] REG_CLAMP  = 2'd1;
  localparam logic [1:0] REG_SNAP   = 2'd2;
  localparam logic [1:0] REG_FREEZE = 2'd3;

  localparam logic [DIV_W-1:0] ONE_Q8 = 16'd256;
  localparam logic [40:0] STEP_LIMIT  = 41'd131072;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] PI_Q13      = 20'sd25736;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANG_W-1:0] angle_t;

  typedef struct packed {
    logic start;
    logic jump;
  } lane_cmd_t;

  function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
    logic signed [19:0] r;
    case (i)
      5'd0:    r = 20'sd51472;
      5'd1:    r = 20'sd30386;
      5'd2:    r = 20'sd16055;
      5'd3:    r = 20'sd8150;
      5'd4:    r = 20'sd4091;
      5'd5:    r = 20'sd2047;
      5'd6:    r = 20'sd1024;
      5'd7:    r = 20'sd512;
      5'd8:    r = 20'sd256;
      5'd9:    r = 20'sd128;
      5'd10:   r = 20'sd64;
      5'd11:   r = 20'sd32;
      5'd12:   r = 20'sd16;
      5'd13:   r = 20'sd8;
      5'd14:   r = 20'sd4;
      5'd15:   r = 20'sd2;
      5'd16:   r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/eetf_lane.sv
// eetf_lane: one coordinate of one point, eased toward its goal per step
// serial restoring divider, step clamp, saturating add and snap; uses eetf_pkg
module eetf_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  eetf_pkg::lane_cmd_t              cmd,
  input  logic [eetf_pkg::DIV_W-1:0]       divisor,
  input  logic                             clamp,
  input  logic [eetf_pkg::SNAP_W-1:0]      snap,
  input  eetf_pkg::coord_t                 goal,
  output eetf_pkg::coord_t                 point,
  output logic                             done
);

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_ABS   = 3'd1;
  localparam logic [2:0] L_DIV   = 3'd2;
  localparam logic [2:0] L_CLAMP = 3'd3;
  localparam logic [2:0] L_ADD   = 3'd4;
  localparam logic [2:0] L_SNAP  = 3'd5;

  logic [2:0]          st;
  eetf_pkg::coord_t    cur;
  eetf_pkg::coord_t    nv;
  logic signed [32:0]  diffr;
  logic                neg;
  logic [40:0]         num;
  logic [40:0]         quo;
  logic [15:0]         rem;
  logic [5:0]          bitcnt;
  logic signed [41:0]  move;

  logic [16:0]         trial;
  logic                fits;
  logic [40:0]         qm;
  logic signed [42:0]  sum;
  logic signed [33:0]  dd;
  logic signed [33:0]  snap_s;
  logic [32:0]         absd;

  assign point = cur;

  always_comb begin
    trial  = {rem, num[40]};
    fits   = trial >= {1'b0, divisor};
    qm     = (clamp && (quo > eetf_pkg::STEP_LIMIT)) ? eetf_pkg::STEP_LIMIT : quo;
    sum    = 43'(cur) + 43'(move);
    dd     = 34'(nv) - 34'(goal);
    snap_s = $signed({13'd0, snap});
    absd   = diffr[32] ? 33'(-diffr) : 33'(diffr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      cur  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        L_IDLE: begin
          if (cmd.start) begin
            if (cmd.jump) begin
              cur  <= goal;
              done <= 1'b1;
            end else begin
              diffr <= 33'(goal) - 33'(cur);
              st    <= L_ABS;
            end
          end
        end
        L_ABS: begin
          neg    <= diffr[32];
          num    <= {absd, 8'd0};
          rem    <= '0;
          quo    <= '0;
          bitcnt <= '0;
          st     <= L_DIV;
        end
        L_DIV: begin
          if (fits) begin
            rem <= 16'(trial - {1'b0, divisor});
          end else begin
            rem <= trial[15:0];
          end
          quo    <= {quo[39:0], fits};
          num    <= {num[39:0], 1'b0};
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'd40) begin
            st <= L_CLAMP;
          end
        end
        L_CLAMP: begin
          move <= neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
          st   <= L_ADD;
        end
        L_ADD: begin
          if (sum > 43'sd2147483647) begin
            nv <= 32'sh7fffffff;
          end else if (sum < -43'sd2147483648) begin
            nv <= 32'sh80000000;
          end else begin
            nv <= sum[31:0];
          end
          st <= L_SNAP;
        end
        L_SNAP: begin
          // strict test on both sides of the goal
          if ((dd < snap_s) && (dd > -snap_s)) begin
            cur <= goal;
          end else begin
            cur <= nv;
          end
          done <= 1'b1;
          st   <= L_IDLE;
        end
        default: st <= L_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/eetf_angle.sv
// eetf_angle: merges the lane points into heading and pitch
// shared multiplier, bit-pair square root and one iterative cordic; uses eetf_pkg
module eetf_angle (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  eetf_pkg::coord_t [2:0]    eye,
  input  eetf_pkg::coord_t [2:0]    look,
  output eetf_pkg::angle_t          heading,
  output eetf_pkg::angle_t          pitch,
  output logic                      done
);

  localparam logic [3:0] A_IDLE  = 4'd0;
  localparam logic [3:0] A_SCALE = 4'd1;
  localparam logic [3:0] A_SQX   = 4'd2;
  localparam logic [3:0] A_SQZ   = 4'd3;
  localparam logic [3:0] A_SUM   = 4'd4;
  localparam logic [3:0] A_SQRT  = 4'd5;
  localparam logic [3:0] A_CLOAD = 4'd6;
  localparam logic [3:0] A_NORM  = 4'd7;
  localparam logic [3:0] A_PRE   = 4'd8;
  localparam logic [3:0] A_ITER  = 4'd9;
  localparam logic [3:0] A_FIN   = 4'd10;
  localparam logic [3:0] A_STORE = 4'd11;

  localparam logic signed [32:0] D_LIM = 33'sd2147483647;
  localparam logic signed [35:0] N_LIM = 36'sd1073741824;

  logic [3:0]          st;
  logic signed [32:0]  dx, dy, dz;
  logic [63:0]         sq, sqacc, v, res, bitv;
  logic signed [35:0]  cx, cy;
  logic signed [19:0]  cz;
  logic [4:0]          idx;
  logic                pass;
  eetf_pkg::angle_t    rz;

  logic                big;
  logic [63:0]         trialv;
  logic signed [35:0]  xs, ys;
  logic signed [19:0]  rr;

  always_comb begin
    big    = (dx > D_LIM) || (dx < -D_LIM) || (dy > D_LIM) || (dy < -D_LIM) ||
             (dz > D_LIM) || (dz < -D_LIM);
    trialv = res + bitv;
    xs     = cx >>> idx;
    ys     = cy >>> idx;
    rr     = (cz + 20'sd4) >>> 3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= A_IDLE;
      done    <= 1'b0;
      heading <= '0;
      pitch   <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (start) begin
            dx <= 33'(look[0]) - 33'(eye[0]);
            dy <= 33'(look[1]) - 33'(eye[1]);
            dz <= 33'(look[2]) - 33'(eye[2]);
            st <= A_SCALE;
          end
        end
        A_SCALE: begin
          if (big) begin
            dx <= dx >>> 2;
            dy <= dy >>> 2;
            dz <= dz >>> 2;
          end
          st <= A_SQX;
        end
        A_SQX: begin
          sq <= 64'($signed(dx[31:0]) * $signed(dx[31:0]));
          st <= A_SQZ;
        end
        A_SQZ: begin
          sqacc <= sq;
          sq    <= 64'($signed(dz[31:0]) * $signed(dz[31:0]));
          st    <= A_SUM;
        end
        A_SUM: begin
          v    <= sqacc + sq;
          res  <= '0;
          bitv <= 64'd1 << 62;
          st   <= A_SQRT;
        end
        A_SQRT: begin
          if (v >= trialv) begin
            v   <= v - trialv;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            pass <= 1'b0;
            st   <= A_CLOAD;
          end
        end
        A_CLOAD: begin
          // heading works on (-dz, -dx), pitch on (h, dy)
          if (!pass) begin
            cx <= -36'($signed(dz[31:0]));
            cy <= -36'($signed(dx[31:0]));
          end else begin
            cx <= $signed({4'd0, res[31:0]});
            cy <= 36'($signed(dy[31:0]));
          end
          cz <= '0;
          st <= A_NORM;
        end
        A_NORM: begin
          if ((cy == '0) && !cx[35]) begin
            rz <= '0;
            st <= A_STORE;
          end else if ((cx < N_LIM) && (cx > -N_LIM) && (cy < N_LIM) && (cy > -N_LIM)) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            st <= A_PRE;
          end
        end
        A_PRE: begin
          if (cx[35]) begin
            if (!cy[35]) begin
              cx <= cy;
              cy <= -cx;
              cz <= eetf_pkg::HALF_PI_Q16;
            end else begin
              cx <= -cy;
              cy <= cx;
              cz <= -eetf_pkg::HALF_PI_Q16;
            end
          end
          idx <= '0;
          st  <= A_ITER;
        end
        A_ITER: begin
          if (!cy[35]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + eetf_pkg::atan_q16(idx);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - eetf_pkg::atan_q16(idx);
          end
          idx <= idx + 5'd1;
          if (idx == 5'd16) begin
            st <= A_FIN;
          end
        end
        A_FIN: begin
          if (rr > eetf_pkg::PI_Q13) begin
            rz <= 16'(eetf_pkg::PI_Q13);
          end else if (rr < -eetf_pkg::PI_Q13) begin
            rz <= 16'(-eetf_pkg::PI_Q13);
          end else begin
            rz <= rr[15:0];
          end
          st <= A_STORE;
        end
        A_STORE: begin
          if (!pass) begin
            heading <= rz;
            pass    <= 1'b1;
            st      <= A_CLOAD;
          end else begin
            pitch <= -rz;
            done  <= 1'b1;
            st    <= A_IDLE;
          end
        end
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/eased_eye_target_follower.sv
// eased_eye_target_follower: top level, config registers, step sequencer,
// six easing lanes and the angle unit; uses eetf_pkg, eetf_lane, eetf_angle
//
// Each word in brings goal eye and look-at points and a step count; each word out
// carries the updated points and the heading and pitch in Q3.13 radians. Six
// lanes, one per coordinate, step together; each easing step is paced by the
// serial restoring divider in each lane, while a jump moves the lanes straight
// to the goal. The angle unit takes the square root first, then runs two cordic
// passes, each normalizing the vector first. With freeze set the sequencer skips
// the lanes and the angle unit and goes from accept to the output state, which
// then loads the output register. A new word is taken once the previous result
// has moved into the output register.
module eased_eye_target_follower #(
  parameter int MAX_STEPS = eetf_pkg::MAX_STEPS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // goal_eye_x, goal_eye_y, goal_eye_z, goal_look_x, goal_look_y, goal_look_z,
  // step_count, zero fill
  input  logic [199:0]                       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // eye_x, eye_y, eye_z, look_x, look_y, look_z, heading_angle, pitch_angle
  output logic [223:0]                       m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [eetf_pkg::SNAP_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_STEPS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_ANGLE = 3'd3;
  localparam logic [2:0] S_AWAIT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [eetf_pkg::DIV_W-1:0]   speed_divisor;
  logic                         clamp_enable;
  logic [eetf_pkg::SNAP_W-1:0]  snap_distance;
  logic                         freeze;

  logic [2:0]                   st;
  eetf_pkg::coord_t [5:0]       goal;
  logic signed [eetf_pkg::CNT_W-1:0] step_cnt;
  logic [CW-1:0]                steps_left;
  eetf_pkg::lane_cmd_t          cmd;
  logic                         angle_start;

  logic [eetf_pkg::DIV_W-1:0]   eye_div, look_div;
  logic [CW-1:0]                n_steps;
  eetf_pkg::coord_t [5:0]       pts;
  logic [5:0]                   lane_done;
  eetf_pkg::angle_t             heading, pitch;
  logic                         angle_done;
  logic                         in_acc;

  assign s_axis_tready = (st == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    eye_div  = (speed_divisor == '0) ? eetf_pkg::ONE_Q8 : speed_divisor;
    look_div = (eye_div < eetf_pkg::ONE_Q8) ? eetf_pkg::ONE_Q8 : eye_div;
    if (32'(step_cnt[3:0]) > MAX_STEPS) begin
      n_steps = CW'(MAX_STEPS);
    end else begin
      n_steps = CW'(step_cnt[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_divisor <= eetf_pkg::ONE_Q8;
      clamp_enable  <= 1'b0;
      snap_distance <= 21'd655;
      freeze        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        eetf_pkg::REG_SPEED:  speed_divisor <= cfg_data[eetf_pkg::DIV_W-1:0];
        eetf_pkg::REG_CLAMP:  clamp_enable  <= cfg_data[0];
        eetf_pkg::REG_SNAP:   snap_distance <= cfg_data;
        eetf_pkg::REG_FREEZE: freeze        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      cmd           <= '0;
      angle_start   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cmd         <= '0;
      angle_start <= 1'b0;
      // in the output state a taken word is replaced by the next one below
      if (m_axis_tvalid && m_axis_tready && (st != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < 6; i++) begin
              goal[i] <= s_axis_tdata[32*i +: 32];
            end
            step_cnt <= s_axis_tdata[196:192];
            st       <= freeze ? S_OUT : S_PLAN;
          end
        end
        S_PLAN: begin
          if (step_cnt[4] || ((n_steps != '0) && (eye_div == eetf_pkg::ONE_Q8))) begin
            cmd        <= '{start: 1'b1, jump: 1'b1};
            steps_left <= CW'(1);
            st         <= S_WAIT;
          end else if (n_steps == '0) begin
            st <= S_ANGLE;
          end else begin
            cmd        <= '{start: 1'b1, jump: 1'b0};
            steps_left <= n_steps;
            st         <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (lane_done[0]) begin
            if (steps_left == CW'(1)) begin
              st <= S_ANGLE;
            end else begin
              steps_left <= steps_left - CW'(1);
              cmd        <= '{start: 1'b1, jump: 1'b0};
            end
          end
        end
        S_ANGLE: begin
          angle_start <= 1'b1;
          st          <= S_AWAIT;
        end
        S_AWAIT: begin
          if (angle_done) begin
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {pitch, heading, pts[5], pts[4], pts[3], pts[2], pts[1], pts[0]};
            m_axis_tvalid <= 1'b1;
            st            <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_lane
    eetf_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .divisor ((g < 3) ? eye_div : look_div),
      .clamp   ((g < 3) ? clamp_enable : 1'b0),
      .snap    (snap_distance),
      .goal    (goal[g]),
      .point   (pts[g]),
      .done    (lane_done[g])
    );
  end

  eetf_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .start   (angle_start),
    .eye     (pts[2:0]),
    .look    (pts[5:3]),
    .heading (heading),
    .pitch   (pitch),
    .done    (angle_done)
  );

  // lanes run in lock step, so they finish together
  a_lanes_lock: assert property (@(posedge clk) disable iff (rst)
    (lane_done == 6'b000000) || (lane_done == 6'b111111))
    else $error("lanes out of step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("word taken while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(st) == S_OUT))
    else $error("result shown outside output state");

endmodule
